// File: hdl/lsi_pkg.sv
// ----------------------------------------------------------------------------
// lsi_pkg
// Shared types and constants for the k-way sorted list intersection block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsi_pkg;

  // Default sizing
  localparam int MaxListsDef    = 8;
  localparam int ListDepthDef   = 64;
  localparam int ElementBitsDef = 16;

  // Fixed field widths of the item ports
  localparam int CmdW       = 1;
  localparam int ListIdW    = 3;
  localparam int ElemInW    = 16;
  localparam int NumListsW  = 4;
  localparam int ValueOutW  = 16;

  localparam logic [NumListsW-1:0] NumListsRst = 4'd2;

  // Command codes
  localparam logic [CmdW-1:0] CmdLoad    = 1'b0;
  localparam logic [CmdW-1:0] CmdCompute = 1'b1;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StRead,
    StWait,
    StEval,
    StFinish
  } lsi_state_e;

  // One result item from the sequencer to the output register
  typedef struct packed {
    logic [ValueOutW-1:0] common_value;
    logic                 found;
    logic                 last_result;
    logic                 overflow;
  } lsi_res_t;

endpackage

`default_nettype wire

// File: hdl/lsi_mem.sv
// ----------------------------------------------------------------------------
// lsi_mem
// Element store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsi_mem import lsi_pkg::*; #(
  parameter int Depth = MaxListsDef * ListDepthDef,
  parameter int Width = ElementBitsDef,
  parameter int AddrW = $clog2(Depth)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output      logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write an appended element
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one head per cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hdl/lsi_seq.sv
// ----------------------------------------------------------------------------
// lsi_seq
// Load bookkeeping and pointer-merge sequencer over the element store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsi_seq import lsi_pkg::*; #(
  parameter int MaxLists    = MaxListsDef,
  parameter int ListDepth   = ListDepthDef,
  parameter int ElementBits = ElementBitsDef,
  parameter int AddrW       = $clog2(MaxLists * ListDepth)
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [CmdW-1:0]      command_i,
  input  wire logic [ListIdW-1:0]   list_id_i,
  input  wire logic [ElemInW-1:0]   element_i,
  input  wire logic [NumListsW-1:0] num_lists_i,
  output      logic                 mem_we_o,
  output      logic [AddrW-1:0]     mem_waddr_o,
  output      logic [ElementBits-1:0] mem_wdata_o,
  output      logic [AddrW-1:0]     mem_raddr_o,
  input  wire logic [ElementBits-1:0] mem_rdata_i,
  output      logic                 res_valid_o,
  input  wire logic                 res_ready_i,
  output      lsi_res_t             res_o
);

  localparam int NW = $clog2(MaxLists + 1);
  localparam int LW = (MaxLists > 1) ? $clog2(MaxLists) : 1;
  localparam int PW = $clog2(ListDepth + 1);
  localparam int EW = ElementBits;

  lsi_state_e state_q, state_d;

  logic [PW-1:0] len_q  [MaxLists];
  logic [PW-1:0] len_d  [MaxLists];
  logic [PW-1:0] pos_q  [MaxLists];
  logic [PW-1:0] pos_d  [MaxLists];
  logic [EW-1:0] head_q [MaxLists];
  logic [EW-1:0] head_d [MaxLists];

  logic          ovf_q, ovf_d;
  logic [NW-1:0] n_q, n_d;
  logic [NW-1:0] rd_cnt_q, rd_cnt_d;
  logic          cap_vld_q, cap_vld_d;
  logic [LW-1:0] cap_idx_q, cap_idx_d;
  logic [EW-1:0] max_q, max_d;
  logic [EW-1:0] first_q, first_d;
  logic          eq_q, eq_d;
  logic          pend_vld_q, pend_vld_d;
  logic [EW-1:0] pend_q, pend_d;

  logic [EW-1:0]        elem_w;
  logic [ValueOutW-1:0] pend_out_w;
  logic [LW-1:0]        load_idx;
  logic                 accept;

  // Fit the loaded element and the emitted value to their widths
  if (EW <= ElemInW) begin : g_elem_narrow
    assign elem_w = element_i[EW-1:0];
  end else begin : g_elem_wide
    assign elem_w = {{(EW - ElemInW){1'b0}}, element_i};
  end

  if (EW >= ValueOutW) begin : g_out_narrow
    assign pend_out_w = pend_q[ValueOutW-1:0];
  end else begin : g_out_wide
    assign pend_out_w = {{(ValueOutW - EW){1'b0}}, pend_q};
  end

  assign load_idx = LW'(list_id_i);
  assign accept   = in_valid_i && !in_stall_o;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int l = 0; l < MaxLists; l++) begin
        len_q[l] <= '0;
        pos_q[l] <= '0;
      end
      ovf_q      <= 1'b0;
      n_q        <= '0;
      rd_cnt_q   <= '0;
      cap_vld_q  <= 1'b0;
      cap_idx_q  <= '0;
      eq_q       <= 1'b0;
      pend_vld_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      pos_q      <= pos_d;
      ovf_q      <= ovf_d;
      n_q        <= n_d;
      rd_cnt_q   <= rd_cnt_d;
      cap_vld_q  <= cap_vld_d;
      cap_idx_q  <= cap_idx_d;
      eq_q       <= eq_d;
      pend_vld_q <= pend_vld_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    head_q  <= head_d;
    max_q   <= max_d;
    first_q <= first_d;
    pend_q  <= pend_d;
  end

  // Next state, bookkeeping and merge control
  always_comb begin
    int  n_int;
    logic done;

    n_int = 0;
    done  = 1'b0;

    state_d    = state_q;
    len_d      = len_q;
    pos_d      = pos_q;
    head_d     = head_q;
    ovf_d      = ovf_q;
    n_d        = n_q;
    rd_cnt_d   = rd_cnt_q;
    cap_vld_d  = 1'b0;
    cap_idx_d  = cap_idx_q;
    max_d      = max_q;
    first_d    = first_q;
    eq_d       = eq_q;
    pend_vld_d = pend_vld_q;
    pend_d     = pend_q;

    in_stall_o  = (state_q != StIdle);
    mem_we_o    = 1'b0;
    mem_waddr_o = AddrW'(32'(load_idx) * ListDepth + 32'(len_q[load_idx]));
    mem_wdata_o = elem_w;
    mem_raddr_o = AddrW'(32'(LW'(rd_cnt_q)) * ListDepth + 32'(pos_q[LW'(rd_cnt_q)]));
    res_valid_o = 1'b0;
    res_o.common_value = pend_out_w;
    res_o.found        = 1'b1;
    res_o.last_result  = 1'b0;
    res_o.overflow     = ovf_q;

    // Capture a head that was read in the previous cycle
    if (cap_vld_q) begin
      head_d[cap_idx_q] = mem_rdata_i;
      if (cap_idx_q == '0) begin
        max_d   = mem_rdata_i;
        first_d = mem_rdata_i;
        eq_d    = 1'b1;
      end else begin
        if (mem_rdata_i > max_q) begin
          max_d = mem_rdata_i;
        end
        if (mem_rdata_i != first_q) begin
          eq_d = 1'b0;
        end
      end
    end

    case (state_q)
      StIdle: begin
        if (accept) begin
          if (command_i == CmdLoad) begin
            // Append, drop on a full list, ignore lists out of range
            if (32'(list_id_i) < MaxLists) begin
              if (32'(len_q[load_idx]) >= ListDepth) begin
                ovf_d = 1'b1;
              end else begin
                mem_we_o         = 1'b1;
                len_d[load_idx]  = len_q[load_idx] + PW'(1);
              end
            end
          end else begin
            // Start a merge run
            n_int = 32'(num_lists_i);
            if (n_int == 0) begin
              n_int = 1;
            end
            if (n_int > MaxLists) begin
              n_int = MaxLists;
            end
            n_d = NW'(n_int);
            for (int l = 0; l < MaxLists; l++) begin
              pos_d[l] = '0;
            end
            pend_vld_d = 1'b0;
            state_d    = StCheck;
          end
        end
      end

      StCheck: begin
        // Stop as soon as any taking part list is exhausted
        for (int l = 0; l < MaxLists; l++) begin
          if ((NW'(l) < n_q) && (pos_q[l] >= len_q[l])) begin
            done = 1'b1;
          end
        end
        rd_cnt_d = '0;
        state_d  = done ? StFinish : StRead;
      end

      StRead: begin
        // Issue one head read per cycle
        cap_vld_d = 1'b1;
        cap_idx_d = LW'(rd_cnt_q);
        rd_cnt_d  = rd_cnt_q + NW'(1);
        if (rd_cnt_q == n_q - NW'(1)) begin
          state_d = StWait;
        end
      end

      StWait: begin
        state_d = StEval;
      end

      StEval: begin
        if (eq_q) begin
          // Hand the previous match on; keep the new one pending
          if (pend_vld_q) begin
            res_valid_o = 1'b1;
          end
          if (!pend_vld_q || res_ready_i) begin
            pend_vld_d = 1'b1;
            pend_d     = first_q;
            for (int l = 0; l < MaxLists; l++) begin
              if (NW'(l) < n_q) begin
                pos_d[l] = pos_q[l] + PW'(1);
              end
            end
            state_d = StCheck;
          end
        end else begin
          // Advance every list whose head lags the largest head
          for (int l = 0; l < MaxLists; l++) begin
            if ((NW'(l) < n_q) && (head_q[l] < max_q)) begin
              pos_d[l] = pos_q[l] + PW'(1);
            end
          end
          state_d = StCheck;
        end
      end

      StFinish: begin
        // Emit the final item, then clear all lists
        res_valid_o       = 1'b1;
        res_o.last_result = 1'b1;
        if (!pend_vld_q) begin
          res_o.common_value = '0;
          res_o.found        = 1'b0;
        end
        if (res_ready_i) begin
          for (int l = 0; l < MaxLists; l++) begin
            len_d[l] = '0;
            pos_d[l] = '0;
          end
          ovf_d      = 1'b0;
          pend_vld_d = 1'b0;
          state_d    = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/sorted_list_multiway_intersection_top.sv
// ----------------------------------------------------------------------------
// sorted_list_multiway_intersection_top
// K-way intersection of ascending lists by pointer merge over an element store.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake              Payload
//  in        input      in_valid_i/in_stall_o  command_i, list_id_i, element_i
//  out       output     out_valid_o/out_stall_i common_value_o, found_o,
//                                               last_result_o, overflow_o
//  cfg       input      cfg_wr_en_i            cfg_wr_data_i (num_lists)
//
//  Loads may arrive back to back.
//  A compute item runs merge steps, each a check, n head reads through the
//  single store read port, a read wait and an evaluate, n being the number
//  of lists taking part, then a last check that finds a list exhausted and
//  a finish step that emits the final result.
//  Output stalls hold the merge at its next result. Reset needs no clearing
//  pass: list lengths are cleared at once, so unwritten entries are never read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_list_multiway_intersection_top import lsi_pkg::*; #(
  parameter int MaxLists    = MaxListsDef,
  parameter int ListDepth   = ListDepthDef,
  parameter int ElementBits = ElementBitsDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_wr_en_i,
  input  wire logic [NumListsW-1:0] cfg_wr_data_i,
  input  wire logic                 in_valid_i,
  output      logic                 in_stall_o,
  input  wire logic [CmdW-1:0]      command_i,
  input  wire logic [ListIdW-1:0]   list_id_i,
  input  wire logic [ElemInW-1:0]   element_i,
  output      logic                 out_valid_o,
  input  wire logic                 out_stall_i,
  output      logic [ValueOutW-1:0] common_value_o,
  output      logic                 found_o,
  output      logic                 last_result_o,
  output      logic                 overflow_o
);

  localparam int Depth = MaxLists * ListDepth;
  localparam int AddrW = $clog2(Depth);

  logic [NumListsW-1:0]   num_lists_q;
  logic                   mem_we;
  logic [AddrW-1:0]       mem_waddr;
  logic [ElementBits-1:0] mem_wdata;
  logic [AddrW-1:0]       mem_raddr;
  logic [ElementBits-1:0] mem_rdata;
  logic                   res_valid;
  logic                   res_ready;
  lsi_res_t               res;
  logic                   out_valid_q;
  lsi_res_t               out_q;

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_lists_q <= NumListsRst;
    end else if (cfg_wr_en_i) begin
      num_lists_q <= cfg_wr_data_i;
    end
  end

  lsi_mem #(
    .Depth (Depth),
    .Width (ElementBits),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  lsi_seq #(
    .MaxLists    (MaxLists),
    .ListDepth   (ListDepth),
    .ElementBits (ElementBits),
    .AddrW       (AddrW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .list_id_i   (list_id_i),
    .element_i   (element_i),
    .num_lists_i (num_lists_q),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or draining
  assign res_ready = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign common_value_o = out_q.common_value;
  assign found_o        = out_q.found;
  assign last_result_o  = out_q.last_result;
  assign overflow_o     = out_q.overflow;

endmodule

`default_nettype wire

// File: tb/sorted_list_multiway_intersection_top_tb.sv
// ----------------------------------------------------------------------------
// sorted_list_multiway_intersection_top_tb
// Self-checking bench for the k-way sorted list intersection block. Load and
// compute items go in with random gaps, and results come out under random
// output stalls. A behavioral merge of the same lists predicts every result,
// and each result is compared field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_list_multiway_intersection_top_tb import lsi_pkg::*; ();

  localparam int          NumLists   = MaxListsDef;
  localparam int          Depth      = ListDepthDef;
  localparam int unsigned CycleLimit = 400000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_wr_en_i;
  logic [NumListsW-1:0] cfg_wr_data_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [CmdW-1:0]      command_i;
  logic [ListIdW-1:0]   list_id_i;
  logic [ElemInW-1:0]   element_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [ValueOutW-1:0] common_value_o;
  logic                 found_o;
  logic                 last_result_o;
  logic                 overflow_o;

  // Shadow of the block's lists and setting
  logic [ElemInW-1:0]   shadow_store [NumLists][Depth];
  int                   shadow_len [NumLists];
  bit                   shadow_overflow;
  logic [NumListsW-1:0] shadow_num_lists;

  // Results still owed by the block, oldest first
  lsi_res_t             common_q [$];

  int          errors;
  int          items_sent;
  int          stall_left;
  int unsigned cycle_count;
  bit          in_idle_on;
  bit          out_idle_on;

  sorted_list_multiway_intersection_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_wr_en_i    (cfg_wr_en_i),
    .cfg_wr_data_i  (cfg_wr_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .list_id_i      (list_id_i),
    .element_i      (element_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .common_value_o (common_value_o),
    .found_o        (found_o),
    .last_result_o  (last_result_o),
    .overflow_o     (overflow_o)
  );

  always #1 clk_i = ~clk_i;

  // Merge the participating lists and queue the results they yield
  function automatic void merge_lists();
    int       n;
    int       l;
    int       pos [NumLists];
    bit       live;
    bit       all_equal;
    int       count;
    logic [ElemInW-1:0] first;
    logic [ElemInW-1:0] largest;
    lsi_res_t run_q [$];
    lsi_res_t r;

    n = int'(shadow_num_lists);
    if (n == 0) n = 1;
    if (n > NumLists) n = NumLists;
    for (l = 0; l < NumLists; l++) pos[l] = 0;
    count = 0;
    forever begin
      live = 1'b1;
      for (l = 0; l < n; l++) if (pos[l] >= shadow_len[l]) live = 1'b0;
      if (!live) break;
      first = shadow_store[0][pos[0]];
      largest = first;
      all_equal = 1'b1;
      for (l = 0; l < n; l++) begin
        if (shadow_store[l][pos[l]] != first) all_equal = 1'b0;
        if (shadow_store[l][pos[l]] > largest) largest = shadow_store[l][pos[l]];
      end
      if (all_equal) begin
        if (count < Depth) begin
          r.common_value = first;
          r.found        = 1'b1;
          r.last_result  = 1'b0;
          r.overflow     = shadow_overflow;
          run_q.insert(run_q.size(), r);
          count++;
        end
        for (l = 0; l < n; l++) pos[l]++;
      end else begin
        for (l = 0; l < n; l++) if (shadow_store[l][pos[l]] < largest) pos[l]++;
      end
    end
    // Empty intersection still yields one result, marked not found
    if (count == 0) begin
      r.common_value = '0;
      r.found        = 1'b0;
      r.last_result  = 1'b0;
      r.overflow     = shadow_overflow;
      run_q.insert(run_q.size(), r);
    end
    run_q[run_q.size()-1].last_result = 1'b1;
    foreach (run_q[i]) common_q.insert(common_q.size(), run_q[i]);
    for (l = 0; l < NumLists; l++) shadow_len[l] = 0;
    shadow_overflow = 1'b0;
  endfunction

  // Apply one accepted item to the shadow state
  function automatic void predict_item(logic [CmdW-1:0] cmd, logic [ListIdW-1:0] id,
                                       logic [ElemInW-1:0] elem);
    if (cmd == CmdCompute) begin
      merge_lists();
    end else if (int'(id) < NumLists) begin
      if (shadow_len[id] >= Depth) begin
        shadow_overflow = 1'b1;
      end else begin
        shadow_store[id][shadow_len[id]] = elem;
        shadow_len[id]++;
      end
    end
  endfunction

  // Drive one item after a random gap and hold it until accepted
  task automatic send_item(logic [CmdW-1:0] cmd, logic [ListIdW-1:0] id,
                           logic [ElemInW-1:0] elem);
    int gap;
    bit taken;
    gap = in_idle_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    command_i  = cmd;
    list_id_i  = id;
    element_i  = elem;
    in_valid_i = 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
    end
    predict_item(cmd, id, elem);
    items_sent++;
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic send_compute();
    send_item(CmdCompute, ListIdW'($urandom), ElemInW'($urandom));
  endtask

  // Drain all owed results, let the block settle, then write the setting
  task automatic write_num_lists(logic [NumListsW-1:0] value);
    while (common_q.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_wr_data_i = value;
    cfg_wr_en_i   = 1'b1;
    shadow_num_lists = value;
    @(negedge clk_i);
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = NumListsW'($urandom);
  endtask

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk_i) begin
    lsi_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (common_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0h found %b last %b ovf %b",
                 $time, common_value_o, found_o, last_result_o, overflow_o);
        errors++;
      end else begin
        want = common_q.pop_front();
        check_field("common_value", want.common_value, common_value_o);
        check_field("found", want.found, found_o);
        check_field("last_result", want.last_result, last_result_o);
        check_field("overflow", want.overflow, overflow_o);
      end
      stall_left = out_idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  // Stall the output for the drawn number of cycles
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_stall_i = 1'b1;
      stall_left--;
    end else begin
      out_stall_i = 1'b0;
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout with %0d results still owed", $time, common_q.size());
      $display("sorted_list_multiway_intersection_top_tb: done, errors");
      $finish;
    end
  end

  // Reset setting of two lists, with one list outside the merge
  task automatic test_default_setting();
    send_item(CmdLoad, 3'd0, 16'h0000);
    send_item(CmdLoad, 3'd0, 16'hFFFF);
    send_item(CmdLoad, 3'd1, 16'hFFFF);
    send_item(CmdLoad, 3'd2, 16'h1234);
    send_compute();
  endtask

  // Zero saturates to one list, fifteen to all lists; empty lists give no match
  task automatic test_setting_extremes();
    int l;
    write_num_lists(4'd0);
    send_compute();
    send_item(CmdLoad, 3'd0, 16'h0003);
    send_item(CmdLoad, 3'd0, 16'h8000);
    send_compute();
    write_num_lists(4'd15);
    for (l = 0; l < NumLists; l++) send_item(CmdLoad, ListIdW'(l), 16'h5AA5);
    send_compute();
  endtask

  // Lists out of order still merge by the same rule
  task automatic test_unsorted_lists();
    write_num_lists(4'd3);
    send_item(CmdLoad, 3'd0, 16'd9);
    send_item(CmdLoad, 3'd0, 16'd2);
    send_item(CmdLoad, 3'd0, 16'd5);
    send_item(CmdLoad, 3'd1, 16'd2);
    send_item(CmdLoad, 3'd1, 16'd9);
    send_item(CmdLoad, 3'd1, 16'd5);
    send_item(CmdLoad, 3'd2, 16'd5);
    send_item(CmdLoad, 3'd2, 16'd9);
    send_compute();
  endtask

  // Overfill one list: the most results, with the overflow flag, then a clear
  task automatic test_full_list();
    int i;
    write_num_lists(4'd1);
    in_idle_on = 1'b0;
    for (i = 0; i < Depth + 2; i++) send_item(CmdLoad, 3'd0, ElemInW'(i * 1000));
    send_item(CmdLoad, 3'd5, 16'h00FF);
    send_compute();
    send_compute();
    in_idle_on = 1'b1;
  endtask

  // Mostly sorted lists that share a few values, with some noise and broken order
  task automatic test_random_merges();
    logic [ElemInW-1:0] lists [NumLists][$];
    logic [ElemInW-1:0] commons [$];
    logic [ElemInW-1:0] v;
    int n;
    int l;
    int c;
    int k;
    int idx;
    int shape;
    int extras;
    int remaining;
    int top;
    bit ordered;

    while (items_sent < 120) begin
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 4) == 0) write_num_lists(NumListsW'($urandom));
        else write_num_lists(NumListsW'($urandom_range(1, 8)));
      end
      in_idle_on  = $urandom_range(0, 3) != 0;
      out_idle_on = $urandom_range(0, 3) != 0;
      n = int'(shadow_num_lists);
      if (n == 0) n = 1;
      if (n > NumLists) n = NumLists;
      top = $urandom_range(0, 1) ? 16'hFFFF : 63;
      shape = $urandom_range(0, 9);
      commons.delete();
      for (c = 0; c < $urandom_range(0, 3); c++) begin
        commons.insert(commons.size(), ElemInW'($urandom_range(0, top)));
      end
      // Build each list, sorted unless this is a noise or broken set
      for (l = 0; l < NumLists; l++) begin
        lists[l].delete();
        if (l >= n && !(shape == 0 || $urandom_range(0, 7) == 0)) continue;
        ordered = !(shape == 0 || (shape == 1 && l == 0));
        extras = $urandom_range(0, 3);
        for (k = 0; k < commons.size() + extras; k++) begin
          v = (k < commons.size()) ? commons[k] : ElemInW'($urandom_range(0, top));
          idx = lists[l].size();
          if (ordered) begin
            idx = 0;
            while (idx < lists[l].size() && lists[l][idx] <= v) idx++;
          end
          lists[l].insert(idx, v);
        end
      end
      // Interleave loads across lists, keeping order within each list
      remaining = 0;
      for (l = 0; l < NumLists; l++) remaining += lists[l].size();
      while (remaining > 0) begin
        l = $urandom_range(0, NumLists - 1);
        if (lists[l].size() != 0) begin
          send_item(CmdLoad, ListIdW'(l), lists[l].pop_front());
          remaining--;
        end
      end
      send_compute();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_wr_en_i   = 1'b0;
    cfg_wr_data_i = '0;
    in_valid_i    = 1'b0;
    command_i     = CmdLoad;
    list_id_i     = '0;
    element_i     = '0;
    out_stall_i   = 1'b0;
    errors        = 0;
    items_sent    = 0;
    stall_left    = 0;
    cycle_count   = 0;
    in_idle_on    = 1'b1;
    out_idle_on   = 1'b1;
    shadow_overflow  = 1'b0;
    shadow_num_lists = NumListsRst;
    for (int l = 0; l < NumLists; l++) shadow_len[l] = 0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_default_setting();
    test_setting_extremes();
    test_unsorted_lists();
    test_full_list();
    test_random_merges();

    // Drain, then give the block time to show any stray result
    in_valid_i = 1'b0;
    while (common_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
    if (errors == 0) begin
      $display("sorted_list_multiway_intersection_top_tb: done, clean");
    end else begin
      $display("sorted_list_multiway_intersection_top_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sorted_list_multiway_intersection_top.f
hdl/lsi_pkg.sv
hdl/lsi_mem.sv
hdl/lsi_seq.sv
hdl/sorted_list_multiway_intersection_top.sv
tb/sorted_list_multiway_intersection_top_tb.sv
